// ===== rtl/core/sactl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sactl_pkg: shared types and constants of the cache tag and LRU controller
// Holds the operation, request and line-state codes, the channel payloads,
// the controller state type and the lookup status record.
// ----------------------------------------------------------------------------
package sactl_pkg;

  // Operation codes carried by the input beat. Codes five to seven are unused.
  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_WRITE = 3'd1,
    OP_FETCH = 3'd2,
    OP_EVICT = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  // Request toward the next level of the hierarchy.
  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_RFO   = 2'd2,
    REQ_WTHRU = 2'd3
  } req_t;

  // State of the touched line after the access.
  typedef enum logic [1:0] {
    LS_INVALID  = 2'd0,
    LS_VALID    = 2'd1,
    LS_MODIFIED = 2'd2
  } lstate_t;

  // Controller sequencing.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } ctl_state_t;

  // Write count saturation value and the count at which a line is modified.
  localparam logic [1:0] WC_MAX   = 2'd3;
  localparam logic [1:0] WC_DIRTY = 2'd2;

  // Input beat.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] address;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [1:0]  next_level_request;
    logic [1:0]  line_state;
    logic [31:0] reads_so_far;
    logic [31:0] writes_so_far;
    logic [31:0] hits_so_far;
    logic [31:0] misses_so_far;
  } out_item_t;

  // Outcome of one set lookup, handed from the set logic to the controller.
  typedef struct packed {
    logic    hit;
    logic    miss;
    req_t    req;
    lstate_t lstate;
  } status_t;

  // Floor of the base-two logarithm, evaluated at elaboration.
  function automatic int floor_log2(input longint unsigned v);
    int n;
    longint unsigned x;
    n = 0;
    x = v;
    while (x > 64'd1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sactl_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sactl_stream_if: valid/ready stream channel
// One beat moves at a rising clock edge where valid and ready are both high.
// The payload type is chosen by the instance.
// ----------------------------------------------------------------------------
interface sactl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sactl_tag_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sactl_tag_ram: set store of the cache controller
// Simple dual-port synchronous memory, one row per set, with a registered
// read port and one write port.
// ----------------------------------------------------------------------------
module sactl_tag_ram #(
  parameter int ADDR_W = 14,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sactl_set_logic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sactl_set_logic: tag compare and replacement update of one set
// Takes the row read from the set store, finds a hit, an invalid way or the
// oldest way, and builds the updated row together with the access outcome.
// ----------------------------------------------------------------------------
module sactl_set_logic #(
  parameter int WAYS   = 4,
  parameter int TAG_W  = 12,
  parameter int RANK_W = 2,
  parameter int WAY_W  = 2
) (
  input  wire logic [2:0]                      op,
  input  wire logic [TAG_W-1:0]                tag,
  input  wire logic [WAYS*(3+RANK_W+TAG_W)-1:0] row_in,
  output logic      [WAYS*(3+RANK_W+TAG_W)-1:0] row_out,
  output logic      [WAY_W-1:0]                way,
  output sactl_pkg::status_t                   status
);

  localparam int ENT_W = 3 + RANK_W + TAG_W;
  localparam logic [RANK_W-1:0] OLDEST = RANK_W'(WAYS - 1);

  logic [WAYS-1:0]   v;
  logic [WAYS-1:0]   match;
  logic [1:0]        wc  [WAYS];
  logic [RANK_W-1:0] rk  [WAYS];
  logic [TAG_W-1:0]  tg  [WAYS];
  logic [WAYS-1:0]   nv;
  logic [1:0]        nwc [WAYS];
  logic [RANK_W-1:0] nrk [WAYS];
  logic [TAG_W-1:0]  ntg [WAYS];

  logic              is_acc;
  logic              is_wr;
  logic              is_ev;
  logic              hit_any;
  logic              inv_any;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  old_way;
  logic [WAY_W-1:0]  sel_way;
  logic [RANK_W-1:0] sel_rank;
  logic [1:0]        new_wc;

  // Split the row into its entries and compare tags.
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      tg[j]    = row_in[j*ENT_W +: TAG_W];
      rk[j]    = row_in[j*ENT_W + TAG_W +: RANK_W];
      wc[j]    = row_in[j*ENT_W + TAG_W + RANK_W +: 2];
      v[j]     = row_in[j*ENT_W + ENT_W - 1];
      match[j] = v[j] && (tg[j] == tag);
    end
  end

  // First matching way, first invalid way, and the valid way of oldest rank.
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_way = WAY_W'(j);
      end
      if (!v[j]) begin
        inv_way = WAY_W'(j);
      end
      if (v[j] && (rk[j] == OLDEST)) begin
        old_way = WAY_W'(j);
      end
    end
  end

  // Decode and select the way that this access touches.
  always_comb begin
    is_wr   = (op == sactl_pkg::OP_WRITE);
    is_ev   = (op == sactl_pkg::OP_EVICT);
    is_acc  = (op == sactl_pkg::OP_READ) || is_wr || (op == sactl_pkg::OP_FETCH);
    hit_any = |match;
    inv_any = !(&v);
    if (is_acc && !hit_any) begin
      sel_way = inv_any ? inv_way : old_way;
    end else begin
      sel_way = hit_way;
    end
    sel_rank = rk[sel_way];
    // Write count of the touched line afterward.
    if (!hit_any) begin
      new_wc = is_wr ? 2'd1 : 2'd0;
    end else if (is_wr && (wc[sel_way] != sactl_pkg::WC_MAX)) begin
      new_wc = wc[sel_way] + 2'd1;
    end else begin
      new_wc = wc[sel_way];
    end
  end

  // Build the updated entries: touch on access, close up ranks on evict.
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      nv[j]  = v[j];
      nwc[j] = wc[j];
      nrk[j] = rk[j];
      ntg[j] = tg[j];
      if (is_acc) begin
        if (WAY_W'(j) == sel_way) begin
          nv[j]  = 1'b1;
          nwc[j] = new_wc;
          nrk[j] = '0;
          ntg[j] = tag;
        end else if (v[j] && ((!hit_any && inv_any) || (rk[j] < sel_rank))) begin
          nrk[j] = rk[j] + RANK_W'(1);
        end
      end else if (is_ev && hit_any) begin
        if (WAY_W'(j) == sel_way) begin
          nv[j]  = 1'b0;
          nwc[j] = '0;
          nrk[j] = '0;
          ntg[j] = '0;
        end else if (v[j] && (rk[j] > sel_rank)) begin
          nrk[j] = rk[j] - RANK_W'(1);
        end
      end
    end
  end

  // Pack the row back.
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      row_out[j*ENT_W +: ENT_W] = {nv[j], nwc[j], nrk[j], ntg[j]};
    end
  end

  // Outcome of the access.
  always_comb begin
    status.hit  = (is_acc || is_ev) && hit_any;
    status.miss = is_acc && !hit_any;
    if (is_acc && !hit_any) begin
      status.req = is_wr ? sactl_pkg::REQ_RFO : sactl_pkg::REQ_READ;
    end else if (is_acc && is_wr && (new_wc == sactl_pkg::WC_MAX)) begin
      status.req = sactl_pkg::REQ_WTHRU;
    end else begin
      status.req = sactl_pkg::REQ_NONE;
    end
    if (!is_acc) begin
      status.lstate = sactl_pkg::LS_INVALID;
    end else if (new_wc >= sactl_pkg::WC_DIRTY) begin
      status.lstate = sactl_pkg::LS_MODIFIED;
    end else begin
      status.lstate = sactl_pkg::LS_VALID;
    end
    way = (status.hit || status.miss) ? sel_way : '0;
  end

endmodule
`default_nettype wire

// ===== rtl/core/set_assoc_cache_tag_lru_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_core: tag and LRU state controller of one cache
// Takes an op and a byte address per input beat and returns one result beat
// with the access outcome and the running read, write, hit and miss counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries {op, address}; out_ch carries one result per input beat.
//   Both are valid/ready channels; a beat moves when valid and ready are high.
//   Each access reads its set row from the set store in the accept cycle and
//   writes the updated row back from the lookup step once the result register
//   is free. A new item is accepted only after the lookup step of the last one
//   is done. The registered read port of the set store sits between the accept
//   and the lookup step. The result is registered when the lookup step is done.
//   A stalled receiver holds the result in the output register; the next
//   item is still accepted and waits in the lookup step until the register
//   is free.
//   Reset starts a clearing pass that writes every set row once, all 2**IB
//   rows (16384 with the default geometry), IB being the floor log2 of
//   SETS. A clear op returns its result at once and then runs the same pass.
//   in_ch.ready stays low during the pass.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lru_core #(
  parameter int SETS       = 16384,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input wire logic       clk,
  input wire logic       rst_n,
  sactl_stream_if.sink   in_ch,
  sactl_stream_if.source out_ch
);

  // Address split and storage geometry.
  localparam int OB       = sactl_pkg::floor_log2(longint'(LINE_BYTES));
  localparam int IB       = sactl_pkg::floor_log2(longint'(SETS));
  localparam int EFF_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int TAG_W    = (EFF_BITS > OB + IB) ? (EFF_BITS - OB - IB) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int ROW_W    = WAYS * (3 + RANK_W + TAG_W);
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << EFF_BITS) - 64'd1);

  sactl_pkg::ctl_state_t state_r, state_nxt;
  logic [IB-1:0]         clr_idx_r, clr_idx_nxt;
  logic [2:0]            op_r;
  logic [IB-1:0]         set_r;
  logic [TAG_W-1:0]      tag_r;
  logic [31:0]           rd_cnt_r, rd_cnt_nxt;
  logic [31:0]           wr_cnt_r, wr_cnt_nxt;
  logic [31:0]           hit_cnt_r, hit_cnt_nxt;
  logic [31:0]           miss_cnt_r, miss_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sactl_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                  in_fire;
  logic                  lk_done;
  logic [31:0]           addr_eff;
  logic [IB-1:0]         in_set;
  logic [TAG_W-1:0]      in_tag;
  logic                  mem_we;
  logic [IB-1:0]         mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;
  logic [ROW_W-1:0]      row_rd;
  logic [ROW_W-1:0]      row_upd;
  logic [WAY_W-1:0]      lk_way;
  logic [WAY_W+1:0]      way_ext;
  sactl_pkg::status_t    lk_status;
  logic                  is_rd_op;

  // Address split of the incoming beat.
  always_comb begin
    addr_eff = in_ch.data.address & ADDR_MASK;
    in_set   = IB'(addr_eff >> OB);
    in_tag   = TAG_W'(addr_eff >> (OB + IB));
  end

  assign in_fire = in_ch.valid && in_ch.ready;

  // Set store.
  sactl_tag_ram #(
    .ADDR_W (IB),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_set),
    .rd_data (row_rd),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  // Hit detection and replacement update of the addressed set.
  sactl_set_logic #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W),
    .WAY_W  (WAY_W)
  ) u_set (
    .op      (op_r),
    .tag     (tag_r),
    .row_in  (row_rd),
    .row_out (row_upd),
    .way     (lk_way),
    .status  (lk_status)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sactl_pkg::ST_CLEAR: begin
        if (&clr_idx_r) begin
          state_nxt = sactl_pkg::ST_IDLE;
        end
      end
      sactl_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = sactl_pkg::ST_LOOKUP;
        end
      end
      sactl_pkg::ST_LOOKUP: begin
        if (lk_done) begin
          state_nxt = (op_r == sactl_pkg::OP_CLEAR) ? sactl_pkg::ST_CLEAR
                                                    : sactl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sactl_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs: handshake, lookup completion and store writes.
  always_comb begin
    in_ch.ready = 1'b0;
    lk_done     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = set_r;
    mem_wdata   = row_upd;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      sactl_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = '0;
        clr_idx_nxt = clr_idx_r + IB'(1);
      end
      sactl_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      sactl_pkg::ST_LOOKUP: begin
        lk_done = !out_valid_r || out_ch.ready;
        mem_we  = lk_done && (op_r <= sactl_pkg::OP_EVICT);
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Running counters.
  always_comb begin
    is_rd_op     = (op_r == sactl_pkg::OP_READ) || (op_r == sactl_pkg::OP_FETCH);
    rd_cnt_nxt   = rd_cnt_r;
    wr_cnt_nxt   = wr_cnt_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (lk_done) begin
      if (op_r == sactl_pkg::OP_CLEAR) begin
        rd_cnt_nxt   = '0;
        wr_cnt_nxt   = '0;
        hit_cnt_nxt  = '0;
        miss_cnt_nxt = '0;
      end else begin
        rd_cnt_nxt   = rd_cnt_r + {31'd0, is_rd_op};
        wr_cnt_nxt   = wr_cnt_r + {31'd0, op_r == sactl_pkg::OP_WRITE};
        hit_cnt_nxt  = hit_cnt_r + {31'd0, lk_status.hit && !lk_status.miss
                                           && (op_r != sactl_pkg::OP_EVICT)};
        miss_cnt_nxt = miss_cnt_r + {31'd0, lk_status.miss};
      end
    end
  end

  // Result register.
  always_comb begin
    way_ext       = {2'b00, lk_way};
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (lk_done) begin
      out_valid_nxt                   = 1'b1;
      out_data_nxt.hit                = lk_status.hit;
      out_data_nxt.way                = way_ext[1:0];
      out_data_nxt.next_level_request = lk_status.req;
      out_data_nxt.line_state         = lk_status.lstate;
      out_data_nxt.reads_so_far       = rd_cnt_nxt;
      out_data_nxt.writes_so_far      = wr_cnt_nxt;
      out_data_nxt.hits_so_far        = hit_cnt_nxt;
      out_data_nxt.misses_so_far      = miss_cnt_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sactl_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.data.op;
      set_r <= in_set;
      tag_r <= in_tag;
    end
    out_data_r <= out_data_nxt;
  end

  // An accepted beat always moves on to the lookup step.
  a_fire_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == sactl_pkg::ST_LOOKUP))
    else $error("accepted beat did not enter lookup");

  // The store is never written in the cycle a new set is read.
  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !mem_we)
    else $error("set store written while a new set is read");

  // A hit never asks the next level for a line.
  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.hit) |->
      ((out_ch.data.next_level_request != sactl_pkg::REQ_READ) &&
       (out_ch.data.next_level_request != sactl_pkg::REQ_RFO)))
    else $error("hit result carries a fill request");

  // Every finished read, write or fetch bumps exactly one of hits and misses.
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (lk_done && (op_r <= sactl_pkg::OP_FETCH)) |=>
      (32'(hit_cnt_r + miss_cnt_r) == 32'($past(hit_cnt_r + miss_cnt_r) + 32'd1)))
    else $error("access did not count as exactly one hit or miss");

  // A filled line is reported valid, never modified.
  a_fill_state: assert property (@(posedge clk) disable iff (!rst_n)
    (lk_done && lk_status.miss) |-> (lk_status.lstate == sactl_pkg::LS_VALID))
    else $error("filled line not reported valid");

endmodule
`default_nettype wire

// ===== dv/tb_set_assoc_cache_tag_lru_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_lru_core: self-checking bench of the cache tag core
// A queue of read, write, fetch, evict, clear and unused-op beats feeds a
// driver; a monitor predicts every accepted access with its own copy of the
// tag, age-rank and write-count state and checks each result beat in order.
// The run steps through several sender and receiver idle mixes, one long
// receiver hold-off, and drains all results between mixes.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_tag_lru_core;

  localparam int SETS       = 16384;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 32;
  localparam int OFF_BITS   = $clog2(LINE_BYTES);
  localparam int SET_BITS   = $clog2(SETS);
  localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - SET_BITS;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  localparam int PHASES         = 4;
  localparam int PHASE_ITEMS    = 425;
  localparam int SET_POOL       = 6;
  localparam int TAG_POOL       = 6;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 60000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sactl_stream_if #(.payload_t(sactl_pkg::in_item_t))  in_ch ();
  sactl_stream_if #(.payload_t(sactl_pkg::out_item_t)) out_ch ();

  set_assoc_cache_tag_lru_core #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (ADDR_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bench-side drive registers, known from time zero.
  logic                drv_valid  = 1'b0;
  sactl_pkg::in_item_t drv_item   = '0;
  logic                sink_ready = 1'b0;

  assign in_ch.valid  = drv_valid;
  assign in_ch.data   = drv_item;
  assign out_ch.ready = sink_ready;

  // Traffic shaping per phase: no idling, sender idle, receiver stall, both.
  int src_idle_by_phase [PHASES] = '{0, 87, 0, 14};
  int snk_stall_by_phase[PHASES] = '{0, 0, 87, 14};
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit hold_go       = 1'b0;
  bit hold_started  = 1'b0;
  int hold_left     = 0;

  sactl_pkg::in_item_t  pending_accesses[$];
  sactl_pkg::out_item_t lookup_results[$];
  bit        beat_taken  = 1'b0;
  int        quiet_run   = 0;
  int        fail_count  = 0;

  // Address pools that keep most traffic inside a few busy sets.
  logic [SET_BITS-1:0] set_pool[SET_POOL];
  logic [TAG_BITS-1:0] tag_pool[TAG_POOL];

  // Predicted cache state.
  logic [TAG_BITS-1:0] line_tag   [SETS][WAYS];
  bit                  line_ok    [SETS][WAYS];
  bit [1:0]            line_rank  [SETS][WAYS];
  bit [1:0]            line_writes[SETS][WAYS];
  logic [31:0] read_count  = '0;
  logic [31:0] write_count = '0;
  logic [31:0] hit_count   = '0;
  logic [31:0] miss_count  = '0;

  // Coverage tallies for the closing summary.
  int accesses_seen  = 0;
  int hits_seen      = 0;
  int misses_seen    = 0;
  int evicts_removed = 0;
  int clears_seen    = 0;
  int ignored_seen   = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Wipe every line and the running counts, as a clear op does.
  task automatic wipe_cache();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        line_ok[s][w]     = 1'b0;
        line_rank[s][w]   = '0;
        line_writes[s][w] = '0;
      end
    end
    read_count  = '0;
    write_count = '0;
    hit_count   = '0;
    miss_count  = '0;
  endtask

  // Make one way most recent; valid lines younger than its old rank age by one.
  task automatic make_recent(input int st, input int way, input int old_rank);
    for (int j = 0; j < WAYS; j++) begin
      if (j != way && line_ok[st][j] && int'(line_rank[st][j]) < old_rank) begin
        line_rank[st][j] = line_rank[st][j] + 2'd1;
      end
    end
    line_rank[st][way] = '0;
  endtask

  // Work out the result of one access and update the predicted state.
  task automatic predict_access(input sactl_pkg::in_item_t item,
                                output sactl_pkg::out_item_t res);
    int                  st;
    logic [TAG_BITS-1:0] tg;
    int                  victim;
    int                  top_rank;
    int                  r;
    bit                  found;
    bit                  picked;
    bit                  is_write;
    st       = int'(item.address[OFF_BITS +: SET_BITS]);
    tg       = item.address[ADDR_BITS-1 -: TAG_BITS];
    res      = '0;
    found    = 1'b0;
    picked   = 1'b0;
    victim   = 0;
    top_rank = -1;
    is_write = (item.op == sactl_pkg::OP_WRITE);
    case (item.op)
      sactl_pkg::OP_CLEAR: begin
        wipe_cache();
        clears_seen++;
      end
      sactl_pkg::OP_EVICT: begin
        for (int w = 0; w < WAYS; w++) begin
          if (!found && line_ok[st][w] && line_tag[st][w] == tg) begin
            r = int'(line_rank[st][w]);
            line_ok[st][w]     = 1'b0;
            line_rank[st][w]   = '0;
            line_writes[st][w] = '0;
            // Close the gap left in the age order.
            for (int j = 0; j < WAYS; j++) begin
              if (line_ok[st][j] && int'(line_rank[st][j]) > r) begin
                line_rank[st][j] = line_rank[st][j] - 2'd1;
              end
            end
            found   = 1'b1;
            res.hit = 1'b1;
            res.way = w[1:0];
            evicts_removed++;
          end
        end
      end
      sactl_pkg::OP_READ, sactl_pkg::OP_WRITE, sactl_pkg::OP_FETCH: begin
        accesses_seen++;
        if (is_write) write_count = write_count + 32'd1;
        else read_count = read_count + 32'd1;
        for (int w = 0; w < WAYS; w++) begin
          if (!found && line_ok[st][w] && line_tag[st][w] == tg) begin
            found     = 1'b1;
            hit_count = hit_count + 32'd1;
            make_recent(st, w, int'(line_rank[st][w]));
            if (is_write) begin
              if (line_writes[st][w] < sactl_pkg::WC_MAX) begin
                line_writes[st][w] = line_writes[st][w] + 2'd1;
              end
              if (line_writes[st][w] == sactl_pkg::WC_MAX) begin
                res.next_level_request = sactl_pkg::REQ_WTHRU;
              end
            end
            res.hit        = 1'b1;
            res.way        = w[1:0];
            res.line_state = (line_writes[st][w] >= sactl_pkg::WC_DIRTY) ?
                             sactl_pkg::LS_MODIFIED : sactl_pkg::LS_VALID;
            hits_seen++;
          end
        end
        if (!found) begin
          miss_count             = miss_count + 32'd1;
          res.next_level_request = is_write ? sactl_pkg::REQ_RFO : sactl_pkg::REQ_READ;
          // First invalid way wins, else the oldest valid way.
          for (int w = 0; w < WAYS; w++) begin
            if (!picked) begin
              if (!line_ok[st][w]) begin
                victim   = w;
                top_rank = -1;
                picked   = 1'b1;
              end else if (int'(line_rank[st][w]) > top_rank) begin
                top_rank = int'(line_rank[st][w]);
                victim   = w;
              end
            end
          end
          make_recent(st, victim, (top_rank >= 0) ? top_rank : WAYS);
          line_ok[st][victim]     = 1'b1;
          line_tag[st][victim]    = tg;
          line_writes[st][victim] = is_write ? 2'd1 : 2'd0;
          res.way                 = victim[1:0];
          res.line_state          = sactl_pkg::LS_VALID;
          misses_seen++;
        end
      end
      default: begin
        ignored_seen++;
      end
    endcase
    res.reads_so_far  = read_count;
    res.writes_so_far = write_count;
    res.hits_so_far   = hit_count;
    res.misses_so_far = miss_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  function automatic logic [31:0] make_address(input logic [TAG_BITS-1:0] tg,
                                               input logic [SET_BITS-1:0] st,
                                               input logic [OFF_BITS-1:0] off);
    return {tg, st, off};
  endfunction

  // Mostly pooled sets and tags so lines hit, age and get replaced.
  function automatic logic [31:0] random_address();
    logic [TAG_BITS-1:0] tg;
    logic [SET_BITS-1:0] st;
    logic [OFF_BITS-1:0] off;
    if ($urandom_range(99) < 8) return $urandom();
    st  = set_pool[$urandom_range(SET_POOL - 1)];
    tg  = tag_pool[$urandom_range(TAG_POOL - 1)];
    off = OFF_BITS'($urandom_range(LINE_BYTES - 1));
    return make_address(tg, st, off);
  endfunction

  function automatic sactl_pkg::in_item_t random_access();
    sactl_pkg::in_item_t it;
    int                  roll;
    roll       = $urandom_range(999);
    it.address = random_address();
    if (roll < 3) it.op = sactl_pkg::OP_CLEAR;
    else if (roll < 20) it.op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    else if (roll < 350) it.op = sactl_pkg::OP_READ;
    else if (roll < 650) it.op = sactl_pkg::OP_WRITE;
    else if (roll < 800) it.op = sactl_pkg::OP_FETCH;
    else it.op = sactl_pkg::OP_EVICT;
    return it;
  endfunction

  function automatic sactl_pkg::in_item_t access(input logic [2:0] op,
                                                 input logic [31:0] address);
    sactl_pkg::in_item_t it;
    it.op      = op;
    it.address = address;
    return it;
  endfunction

  // Input driver: holds a beat until it is taken, then offers the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || beat_taken) begin
      if (pending_accesses.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_item  <= pending_accesses.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      sink_ready <= 1'b0;
    end else if (hold_go && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = LONG_HOLD;
      sink_ready   <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: predict on each input beat, check each result beat in order.
  always @(posedge clk) begin : monitor
    sactl_pkg::out_item_t want;
    sactl_pkg::out_item_t got;
    bit                   result_taken;
    if (rst_n) begin
      beat_taken   = in_ch.valid && in_ch.ready;
      result_taken = out_ch.valid && out_ch.ready;
      if (beat_taken) begin
        predict_access(in_ch.data, want);
        lookup_results.push_back(want);
      end
      if (result_taken) begin
        got = out_ch.data;
        if (lookup_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none expected, actual %0h", $time, got);
        end else begin
          want = lookup_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("way", 32'(want.way), 32'(got.way));
          check_field("next_level_request", 32'(want.next_level_request),
                      32'(got.next_level_request));
          check_field("line_state", 32'(want.line_state), 32'(got.line_state));
          check_field("reads_so_far", want.reads_so_far, got.reads_so_far);
          check_field("writes_so_far", want.writes_so_far, got.writes_so_far);
          check_field("hits_so_far", want.hits_so_far, got.hits_so_far);
          check_field("misses_so_far", want.misses_so_far, got.misses_so_far);
        end
      end
      if (beat_taken || result_taken) quiet_run = 0;
      else quiet_run++;
      if (quiet_run >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat moved for %0d cycles", $time, quiet_run);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus: directed accesses, then random phases with drains in between.
  initial begin : stimulus
    logic [31:0] a1;
    logic [31:0] all_ones;
    logic [TAG_BITS-1:0] t0;
    logic [SET_BITS-1:0] s0;
    wipe_cache();
    for (int i = 0; i < SET_POOL; i++) set_pool[i] = SET_BITS'($urandom_range(SETS - 1));
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = TAG_BITS'($urandom());
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: write-count climb and saturation, fill, LRU victim, evicts.
    s0       = set_pool[0];
    t0       = tag_pool[0];
    all_ones = '1;
    a1       = make_address(t0, s0, '0);
    pending_accesses.push_back(access(sactl_pkg::OP_READ, a1));
    for (int i = 0; i < 4; i++) begin
      pending_accesses.push_back(access(sactl_pkg::OP_WRITE, a1 | 32'(i)));
    end
    pending_accesses.push_back(access(sactl_pkg::OP_WRITE,
                                      make_address(TAG_BITS'(t0 + 1), s0, '1)));
    pending_accesses.push_back(access(sactl_pkg::OP_FETCH,
                                      make_address(TAG_BITS'(t0 + 2), s0, '0)));
    pending_accesses.push_back(access(sactl_pkg::OP_READ,
                                      make_address(TAG_BITS'(t0 + 3), s0, '0)));
    pending_accesses.push_back(access(sactl_pkg::OP_READ,
                                      make_address(TAG_BITS'(t0 + 4), s0, '0)));
    pending_accesses.push_back(access(sactl_pkg::OP_FETCH,
                                      make_address(TAG_BITS'(t0 + 1), s0, '0)));
    pending_accesses.push_back(access(sactl_pkg::OP_EVICT,
                                      make_address(TAG_BITS'(t0 + 2), s0, '0)));
    pending_accesses.push_back(access(sactl_pkg::OP_EVICT,
                                      make_address(TAG_BITS'(t0 + 2), s0, '0)));
    pending_accesses.push_back(access(sactl_pkg::OP_READ,
                                      make_address(TAG_BITS'(t0 + 5), s0, '0)));
    pending_accesses.push_back(access(OP_FIRST_UNUSED, '0));
    pending_accesses.push_back(access(OP_LAST_UNUSED, all_ones));
    pending_accesses.push_back(access(sactl_pkg::OP_READ, all_ones));
    pending_accesses.push_back(access(sactl_pkg::OP_WRITE, all_ones));
    pending_accesses.push_back(access(sactl_pkg::OP_READ, '0));
    pending_accesses.push_back(access(sactl_pkg::OP_CLEAR, $urandom()));
    pending_accesses.push_back(access(sactl_pkg::OP_EVICT, all_ones));
    pending_accesses.push_back(access(sactl_pkg::OP_READ, all_ones));
    pending_accesses.push_back(access(OP_FIRST_UNUSED + 3'd1, $urandom()));

    for (int phase = 0; phase < PHASES; phase++) begin
      src_idle_pct  = src_idle_by_phase[phase];
      snk_stall_pct = snk_stall_by_phase[phase];
      for (int n = 0; n < PHASE_ITEMS; n++) pending_accesses.push_back(random_access());
      // In the unthrottled phase, park the receiver while beats keep coming.
      if (phase == 0) begin
        while (pending_accesses.size() > PHASE_ITEMS / 2) @(posedge clk);
        hold_go = 1'b1;
      end
      // The sender pauses until every expected result is back.
      while (pending_accesses.size() != 0 || drv_valid || lookup_results.size() != 0) begin
        @(posedge clk);
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lookup_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected results never arrived", $time, lookup_results.size());
    end
    $display("Covered %0d accesses (%0d hits, %0d misses), %0d evictions, %0d clears,",
             accesses_seen, hits_seen, misses_seen, evicts_removed, clears_seen);
    $display("%0d unused ops, four idle mixes and a long receiver hold-off.", ignored_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/sactl_pkg.sv
rtl/core/sactl_stream_if.sv
rtl/core/sactl_tag_ram.sv
rtl/core/sactl_set_logic.sv
rtl/core/set_assoc_cache_tag_lru_core.sv
dv/tb_set_assoc_cache_tag_lru_core.sv
